// ===== design/absa_pkg.sv =====
// Shared constants, types and helpers for the angular bin surface averager.
package absa_pkg;

    localparam int BINS       = 16;
    localparam int BIN_BITS   = 4;
    localparam int COUNT_BITS = 16;
    localparam int SUM_BITS   = COUNT_BITS + 32;
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = 25;
    localparam int VAL_W      = 32;
    localparam int ANG_W      = 16;
    localparam int ITER       = 16;
    localparam int ITER_BITS  = 4;
    // vector datapath width: headroom for CORDIC gain
    localparam int VEC_W      = 28;
    localparam int QUO_BITS   = 5;

    // configuration register indexes
    localparam logic [0:0] REG_ORIGIN_X = 1'b0;
    localparam logic [0:0] REG_ORIGIN_Y = 1'b1;
    localparam int CFG_IDX_W = 2;

    // half-turn in turn units
    localparam logic [ANG_W-1:0] HALF_TURN = 16'h8000;

    // atan(2^-i) in turn units
    function automatic logic [ANG_W-1:0] atan_turn(input logic [ITER_BITS-1:0] i);
        logic [ANG_W-1:0] t;
        case (i)
            4'd0:  t = 16'd8192;
            4'd1:  t = 16'd4836;
            4'd2:  t = 16'd2555;
            4'd3:  t = 16'd1297;
            4'd4:  t = 16'd651;
            4'd5:  t = 16'd326;
            4'd6:  t = 16'd163;
            4'd7:  t = 16'd81;
            4'd8:  t = 16'd41;
            4'd9:  t = 16'd20;
            4'd10: t = 16'd10;
            4'd11: t = 16'd5;
            4'd12: t = 16'd3;
            4'd13: t = 16'd1;
            4'd14: t = 16'd1;
            default: t = 16'd0;
        endcase
        return t;
    endfunction

    // one bin's accumulated state, passed cell to cell
    typedef struct packed {
        logic signed [SUM_BITS-1:0] psum;
        logic signed [SUM_BITS-1:0] vsum;
        logic [COUNT_BITS-1:0]      cnt;
    } t_bin;

    // point headed into the accumulator chain
    typedef struct packed {
        logic                    hit;
        logic [BIN_BITS-1:0]     idx;
        logic signed [VAL_W-1:0] p;
        logic signed [VAL_W-1:0] v;
    } t_acc;

endpackage

// ===== design/angular_bin_surface_averager_unit.sv =====
// Top level: angle unit, bin cell chain and mean readout of the angular bin averager.
// Each point: CORDIC load, 16 rotations and bin accumulate; a point on the origin skips
// the rotations. o_stall holds off the next point until the CORDIC is done with this one.
// A last point adds BINS readouts, each through two serial dividers of SUM_BITS
// steps plus load and shift, plus output stall time; o_stall stays high through them.
// Reset (synchronous, active low) zeroes origin, all bin sums and counts.
module angular_bin_surface_averager_unit import absa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [COORD_W-1:0]  i_point_x,
    input  logic signed [COORD_W-1:0]  i_point_y,
    input  logic signed [VAL_W-1:0]    i_pressure,
    input  logic signed [VAL_W-1:0]    i_vorticity,
    input  logic                       i_last_point,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COORD_W-1:0]         i_cfg_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [BIN_BITS-1:0]        o_bin_index,
    output logic signed [VAL_W-1:0]    o_mean_pressure,
    output logic signed [VAL_W-1:0]    o_mean_vorticity,
    output logic                       o_last_bin
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ANGLE = 5'b00010,
        S_ACC   = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic signed [COORD_W-1:0] r_org_x, r_org_y;
    logic signed [VAL_W-1:0]   r_p, r_v;
    logic                      r_last;
    logic [BIN_BITS-1:0]       r_out_n;
    logic [BIN_BITS-1:0]       r_obin;
    logic [VAL_W-1:0]          r_omp, r_omv;
    logic                      r_olast;
    logic                      r_ovalid;
    logic                      accept;
    logic                      ang_done;
    logic [ANG_W-1:0]          angle;
    logic signed [DIFF_W-1:0]  dx, dy;
    t_acc                      acc;
    logic                      shift;
    logic                      div_start;
    logic                      divp_done, divv_done;
    logic [VAL_W-1:0]          qp, qv;
    t_bin                      chain [BINS+1];

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
        end else if (i_cfg_we && i_cfg_idx[CFG_IDX_W-1:1] == '0) begin
            if (i_cfg_idx[0] == REG_ORIGIN_X) r_org_x <= i_cfg_data;
            else                              r_org_y <= i_cfg_data;
        end
    end

    assign dx = DIFF_W'(i_point_x) - DIFF_W'(r_org_x);
    assign dy = DIFF_W'(i_point_y) - DIFF_W'(r_org_y);

    absa_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_done  (ang_done),
        .o_angle (angle)
    );

    // nearest bin and 5 degree window
    logic [ANG_W+BIN_BITS:0] scaled;
    logic [QUO_BITS-1:0]     idx_raw;
    logic signed [ANG_W+BIN_BITS+1:0] dd;
    logic [ANG_W+BIN_BITS:0] ad;
    logic [ANG_W+BIN_BITS+7:0] ad72;
    assign scaled  = (ANG_W+BIN_BITS+1)'(angle) * (ANG_W+BIN_BITS+1)'(BINS);
    assign idx_raw = QUO_BITS'((scaled + (ANG_W+BIN_BITS+1)'(32768)) >> ANG_W);
    assign dd      = $signed({1'b0, scaled}) - $signed((ANG_W+BIN_BITS+2)'(idx_raw) << ANG_W);
    assign ad      = dd[ANG_W+BIN_BITS+1] ? (ANG_W+BIN_BITS+1)'(-dd)
                                          : (ANG_W+BIN_BITS+1)'(dd);
    assign ad72    = (ANG_W+BIN_BITS+8)'(ad) * (ANG_W+BIN_BITS+8)'(72);

    always_comb begin
        acc.hit = ad72 < (ANG_W+BIN_BITS+8)'(65536 * BINS);
        acc.idx = (idx_raw >= QUO_BITS'(BINS)) ? '0 : idx_raw[BIN_BITS-1:0];
        acc.p   = r_p;
        acc.v   = r_v;
    end

    // bin cell chain; bin 0 sits in the tail cell and shifts out to readout first
    assign chain[0] = '0;
    for (genvar g = 0; g < BINS; g++) begin : g_cell
        absa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_my_idx (BIN_BITS'(BINS - 1 - g)),
            .i_acc    (acc),
            .i_acc_en (ang_done),
            .i_shift  (shift),
            .i_prev   (chain[g]),
            .o_bin    (chain[g+1])
        );
    end

    absa_div u_divp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (chain[BINS].psum),
        .i_den   (chain[BINS].cnt),
        .o_done  (divp_done),
        .o_quo   (qp)
    );

    absa_div u_divv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (chain[BINS].vsum),
        .i_den   (chain[BINS].cnt),
        .o_done  (divv_done),
        .o_quo   (qv)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        shift     = 1'b0;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_ANGLE;
            S_ANGLE: if (ang_done) n_state = r_last ? S_ACC : S_IDLE;
            S_ACC: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: if (divp_done) n_state = S_OUT;
            S_OUT: if (!r_ovalid || !i_stall) begin
                shift = 1'b1;
                if (r_out_n == BIN_BITS'(BINS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ACC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_out_n  <= '0;
        end else begin
            r_state <= n_state;
            if (shift) begin
                r_ovalid <= 1'b1;
                r_out_n  <= r_out_n + 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (accept) begin
            r_p    <= i_pressure;
            r_v    <= i_vorticity;
            r_last <= i_last_point;
        end
        if (shift) begin
            r_obin  <= r_out_n;
            r_omp   <= qp;
            r_omv   <= qv;
            r_olast <= (r_out_n == BIN_BITS'(BINS - 1));
        end
    end

    assign o_valid          = r_ovalid;
    assign o_bin_index      = r_obin;
    assign o_mean_pressure  = r_omp;
    assign o_mean_vorticity = r_omv;
    assign o_last_bin       = r_olast;

    // checks
    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        divp_done == divv_done) else $error("dividers out of step");
    a_no_shift_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift |-> r_state == S_OUT) else $error("shift outside readout");
    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (shift && r_out_n == BIN_BITS'(BINS - 1)) |=> r_out_n == '0)
        else $error("bin counter did not wrap");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ang_done |-> o_stall) else $error("angle done while idle");
endmodule

// ===== design/absa_cordic.sv =====
// Iterative vectoring CORDIC: angle of (dx, dy) in turn units, one rotation per cycle.
module absa_cordic import absa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_dx,
    input  logic signed [DIFF_W-1:0] i_dy,
    output logic                     o_done,
    output logic [ANG_W-1:0]         o_angle
);
    logic                    r_busy, n_busy;
    logic [ITER_BITS-1:0]    r_i, n_i;
    logic signed [VEC_W-1:0] r_x, n_x, r_y, n_y;
    logic [ANG_W-1:0]        r_z, n_z;
    logic                    r_done, n_done;
    logic signed [VEC_W-1:0] xs, ys, dxe, dye;

    assign dxe = VEC_W'(i_dx);
    assign dye = VEC_W'(i_dy);
    assign xs  = r_x >>> r_i;
    assign ys  = r_y >>> r_i;

    // load, then one micro-rotation per cycle
    always_comb begin
        n_busy = r_busy;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_done = 1'b0;
        if (i_start) begin
            n_i = '0;
            if (i_dx == '0 && i_dy == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_z    = '0;
            end else begin
                n_busy = 1'b1;
                if (i_dx < 0) begin
                    n_x = -dxe;
                    n_y = -dye;
                    n_z = HALF_TURN;
                end else begin
                    n_x = dxe;
                    n_y = dye;
                    n_z = '0;
                end
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + atan_turn(r_i);
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - atan_turn(r_i);
            end
            n_i = r_i + 1'b1;
            if (r_i == ITER_BITS'(ITER - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i <= n_i;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_done  = r_done;
    assign o_angle = r_z;
endmodule

// ===== design/absa_cell.sv =====
// One bin cell: holds a bin's sums and count, adds matching points until its count saturates, shifts during readout.
module absa_cell import absa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [BIN_BITS-1:0] i_my_idx,
    input  t_acc                i_acc,
    input  logic                i_acc_en,
    input  logic                i_shift,
    input  t_bin                i_prev,
    output t_bin                o_bin
);
    t_bin r_bin, n_bin;
    logic cnt_full;

    assign cnt_full = &r_bin.cnt;

    // accumulate, or take neighbor's contents while shifting out
    always_comb begin
        n_bin = r_bin;
        if (i_shift) begin
            n_bin = i_prev;
        end else if (i_acc_en && i_acc.hit && i_acc.idx == i_my_idx && !cnt_full) begin
            n_bin.cnt  = r_bin.cnt + 1'b1;
            n_bin.psum = r_bin.psum + SUM_BITS'(i_acc.p);
            n_bin.vsum = r_bin.vsum + SUM_BITS'(i_acc.v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
        end else begin
            r_bin <= n_bin;
        end
    end

    assign o_bin = r_bin;
endmodule

// ===== design/absa_div.sv =====
// Restoring signed divider: SUM_BITS dividend by COUNT_BITS count, one quotient bit per cycle.
module absa_div import absa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_BITS-1:0] i_num,
    input  logic [COUNT_BITS-1:0]      i_den,
    output logic                       o_done,
    output logic [VAL_W-1:0]           o_quo
);
    localparam int STEP_W = $clog2(SUM_BITS + 1);
    logic                    r_busy;
    logic                    r_done;
    logic [STEP_W-1:0]       r_cnt;
    logic [SUM_BITS-1:0]     r_q;
    logic [COUNT_BITS:0]     r_rem;
    logic [COUNT_BITS-1:0]   r_den;
    logic                    r_neg;
    logic [COUNT_BITS:0]     trial;
    logic [COUNT_BITS:0]     diff;
    logic [SUM_BITS-1:0]     mag;
    logic [SUM_BITS-1:0]     qfin;

    assign mag   = i_num[SUM_BITS-1] ? SUM_BITS'(-i_num) : SUM_BITS'(i_num);
    assign trial = {r_rem[COUNT_BITS-1:0], r_q[SUM_BITS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign qfin  = r_neg ? -r_q : r_q;

    // shift-subtract loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_W'(SUM_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= '0;
            r_q   <= mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[SUM_BITS-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (!diff[COUNT_BITS]) begin
                r_rem <= diff;
                r_q   <= {r_q[SUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_q   <= {r_q[SUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_den == '0) ? '0 : qfin[VAL_W-1:0];
endmodule

// ===== sim/tb_angular_bin_surface_averager_unit.sv =====
// Self-checking testbench for the angular bin surface averager, with a bin-mean scoreboard.
`timescale 1ns / 100ps

module tb_angular_bin_surface_averager_unit import absa_pkg::*; ();

    localparam int          MAX_CYCLES    = 600000;
    localparam int          DRAIN_CYCLES  = 60;
    localparam int          RANDOM_POINTS = 160;
    localparam real         TWO_PI        = 6.283185307179586;
    localparam logic [1:0]  IDX_SPARE_A   = 2'd2;
    localparam logic [1:0]  IDX_SPARE_B   = 2'd3;

    // one expected bin mean beat
    typedef struct {
        logic [BIN_BITS-1:0] idx;
        logic [VAL_W-1:0]    mp;
        logic [VAL_W-1:0]    mv;
        logic                lb;
    } t_bin_mean;

    // keeps its own copy of origin and bin store, queues expected bin means
    class bin_mean_board;
        longint    org_x, org_y;
        longint    p_acc [BINS];
        longint    v_acc [BINS];
        longint    n_pts [BINS];
        t_bin_mean pending[$];
        int        errors;

        function void clear_bins();
            foreach (p_acc[b]) begin
                p_acc[b] = 0;
                v_acc[b] = 0;
                n_pts[b] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [COORD_W-1:0] data);
            if (idx == 2'(REG_ORIGIN_X)) org_x = longint'($signed(data));
            else if (idx == 2'(REG_ORIGIN_Y)) org_y = longint'($signed(data));
        endfunction

        // vectoring CORDIC in turn units
        function longint turn_angle(longint dx, longint dy);
            longint x, y, z, xs, ys;
            x = dx; y = dy; z = 0;
            if (dx == 0 && dy == 0) return 0;
            if (dx < 0) begin
                x = -dx; y = -dy; z = 32768;
            end
            for (int i = 0; i < ITER; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z += atan_turn(4'(i));
                end else begin
                    x = x - ys; y = y + xs; z -= atan_turn(4'(i));
                end
            end
            return z & 64'hFFFF;
        endfunction

        function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                 logic [VAL_W-1:0] p, logic [VAL_W-1:0] v, logic last);
            longint ang, scaled, bin, delta;
            t_bin_mean e;
            ang    = turn_angle(longint'($signed(px)) - org_x, longint'($signed(py)) - org_y);
            scaled = ang * BINS;
            bin    = (scaled * 2 + 65536) / 131072;
            delta  = scaled - bin * 65536;
            if (delta < 0) delta = -delta;
            if (bin >= BINS) bin = 0;
            // only points strictly inside the 5 degree window count
            if (delta * 72 < 65536 * BINS && n_pts[bin] < (64'd1 << COUNT_BITS) - 1) begin
                n_pts[bin]++;
                p_acc[bin] += longint'($signed(p));
                v_acc[bin] += longint'($signed(v));
            end
            if (!last) return;
            for (int b = 0; b < BINS; b++) begin
                e.idx = BIN_BITS'(b);
                e.mp  = (n_pts[b] != 0) ? VAL_W'(p_acc[b] / n_pts[b]) : '0;
                e.mv  = (n_pts[b] != 0) ? VAL_W'(v_acc[b] / n_pts[b]) : '0;
                e.lb  = (b == BINS - 1);
                pending.insert(pending.size(), e);
            end
            clear_bins();
        endfunction

        function void check_result(logic [BIN_BITS-1:0] idx, logic [VAL_W-1:0] mp,
                                   logic [VAL_W-1:0] mv, logic lb);
            t_bin_mean e;
            if (pending.size() == 0) begin
                $error("unexpected bin beat: bin_index %0d", idx);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx) begin
                $error("bin_index: expected %0d, got %0d", e.idx, idx); errors++;
            end
            if (mp !== e.mp) begin
                $error("mean_pressure: expected %h, got %h", e.mp, mp); errors++;
            end
            if (mv !== e.mv) begin
                $error("mean_vorticity: expected %h, got %h", e.mv, mv); errors++;
            end
            if (lb !== e.lb) begin
                $error("last_bin: expected %0d, got %0d", e.lb, lb); errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [COORD_W-1:0]  i_point_x;
    logic signed [COORD_W-1:0]  i_point_y;
    logic signed [VAL_W-1:0]    i_pressure;
    logic signed [VAL_W-1:0]    i_vorticity;
    logic                       i_last_point;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [COORD_W-1:0]         i_cfg_data;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [BIN_BITS-1:0]        o_bin_index;
    logic signed [VAL_W-1:0]    o_mean_pressure;
    logic signed [VAL_W-1:0]    o_mean_vorticity;
    logic                       o_last_bin;

    bin_mean_board board = new();
    int            cycles;
    bit            calm;

    angular_bin_surface_averager_unit i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("angular_bin_surface_averager_unit test failed");
            $finish;
        end
    end

    // result side: random stall, check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_bin_index, o_mean_pressure, o_mean_vorticity, o_last_bin);
        i_stall <= !calm && ($urandom_range(99) < 23);
    end

    function automatic logic [COORD_W-1:0] clamp24(real r);
        if (r > 8388607.0) return 24'h7FFFFF;
        if (r < -8388608.0) return 24'h800000;
        return COORD_W'($rtoi(r));
    endfunction

    task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                              logic [VAL_W-1:0] p, logic [VAL_W-1:0] v, logic last);
        int gap;
        gap = (!calm && $urandom_range(99) < 23) ? $urandom_range(6, 1) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_point_x    <= px;
        i_point_y    <= py;
        i_pressure   <= p;
        i_vorticity  <= v;
        i_last_point <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_point(px, py, p, v, last);
    endtask

    // point at a given turn angle and radius around the current origin
    task automatic send_polar(longint ang, real rad, logic [VAL_W-1:0] p,
                              logic [VAL_W-1:0] v, logic last);
        real a;
        a = TWO_PI * real'(ang) / 65536.0;
        send_point(clamp24(real'(board.org_x) + rad * $cos(a)),
                   clamp24(real'(board.org_y) + rad * $sin(a)), p, v, last);
    endtask

    // only while idle: drain results and let the pipeline empty
    task automatic write_reg(logic [1:0] idx, logic [COORD_W-1:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_reg(idx, data);
    endtask

    initial begin
        int        sent, set_len, bin;
        longint    ang;
        real       rad;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_point_x    <= '0;
        i_point_y    <= '0;
        i_pressure   <= '0;
        i_vorticity  <= '0;
        i_last_point <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        calm         = 1'b0;
        board.org_x  = 0;
        board.org_y  = 0;
        board.clear_bins();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: axes, diagonal, zero offset, window edges, wrap, extremes
        send_point(24'd65536, 24'd0, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_point(24'd0, 24'd65536, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_point(24'h800000, 24'd0, 32'd65536, 32'hFFFF0000, 1'b0);
        send_point(24'd0, 24'h800000, 32'd3, 32'd5, 1'b0);
        send_point(24'd65536, 24'd65536, 32'hFFFFFFFD, 32'd7, 1'b0);
        send_point(24'd0, 24'd0, 32'd100, 32'hFFFFFF9C, 1'b0);
        send_point(24'h7FFFFF, 24'h7FFFFF, 32'd1, 32'hFFFFFFFF, 1'b0);
        send_point(24'h800000, 24'h800000, 32'h12345678, 32'h87654321, 1'b0);
        send_polar(910, 3.0e6, 32'd11, 32'd13, 1'b0);
        send_polar(911, 3.0e6, 32'd17, 32'd19, 1'b0);
        send_polar(4096 - 910, 3.0e6, 32'd23, 32'd29, 1'b0);
        send_polar(2048, 3.0e6, 32'd31, 32'd37, 1'b0);
        send_polar(65535, 3.0e6, 32'd41, 32'd43, 1'b0);
        send_polar(65536 - 910, 3.0e6, 32'd47, 32'd53, 1'b1);
        send_point(24'd1000, 24'd0, 32'd9, 32'd9, 1'b1);

        // extreme origins, spare register indexes
        write_reg(2'(REG_ORIGIN_X), 24'h7FFFFF);
        write_reg(2'(REG_ORIGIN_Y), 24'h800000);
        write_reg(IDX_SPARE_A, 24'h123456);
        send_point(24'h800000, 24'h7FFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        send_point(24'h7FFFFF, 24'h800000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
        write_reg(2'(REG_ORIGIN_X), 24'h800000);
        write_reg(2'(REG_ORIGIN_Y), 24'h7FFFFF);
        write_reg(IDX_SPARE_B, 24'hFFFFFF);
        send_point(24'h7FFFFF, 24'h800000, 32'h80000000, 32'h80000000, 1'b0);
        send_point(24'h7FFFFF, 24'h7FFFFF, 32'h80000000, 32'h1, 1'b1);

        // random sets, mostly points near bin directions
        sent = 0;
        while (sent < RANDOM_POINTS) begin
            if ($urandom_range(3) == 0) begin
                write_reg(2'(REG_ORIGIN_X), 24'($urandom));
                write_reg(2'(REG_ORIGIN_Y), ($urandom_range(1) == 1) ? 24'($urandom)
                                                                   : 24'($urandom_range(2000)));
                if ($urandom_range(3) == 0) write_reg(2'($urandom_range(3, 2)), 24'($urandom));
            end
            calm    = (sent >= 60 && sent < 100);
            set_len = $urandom_range(12, 1);
            for (int k = 0; k < set_len; k++) begin
                if ($urandom_range(3) == 0) begin
                    send_point(24'($urandom), 24'($urandom), $urandom, $urandom,
                               k == set_len - 1);
                end else begin
                    bin = $urandom_range(BINS - 1);
                    ang = longint'(bin) * 4096 + longint'($urandom_range(2400)) - 1200;
                    rad = real'($urandom_range(6000000, 2000));
                    send_polar(ang, rad, ($urandom_range(7) == 0) ? 32'h80000000 : $urandom,
                               ($urandom_range(7) == 0) ? 32'h7FFFFFFF : $urandom,
                               k == set_len - 1);
                end
                sent++;
            end
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        // drain
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("angular_bin_surface_averager_unit test passed");
        else
            $display("angular_bin_surface_averager_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/absa_pkg.sv
design/absa_cordic.sv
design/absa_cell.sv
design/absa_div.sv
design/angular_bin_surface_averager_unit.sv
sim/tb_angular_bin_surface_averager_unit.sv
